// ----- sv/skt_pkg.sv -----
// types and constants shared by the sorted key table
package skt_pkg;

  localparam int unsigned KEY_W      = 63;
  localparam int unsigned PAY_W      = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned OUT_CNT_W  = 5;
  localparam int unsigned S_TDATA_W  = 104;
  localparam int unsigned M_TDATA_W  = 112;
  localparam int unsigned S_USED_W   = KEY_W + PAY_W + IDX_W;
  localparam int unsigned M_USED_W   = OUT_CNT_W + KEY_W + PAY_W + OUT_CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_POSITION = 2'd2,
    CMD_READ_AT  = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_SHIFT_DN = 7'b0000100,
    S_SHIFT_UP = 7'b0001000,
    S_PLACE    = 7'b0010000,
    S_FETCH    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

endpackage

// ----- sv/skt_ram.sv -----
// generic single write, single read ram with registered read data
module skt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sorted_key_table_top.sv -----
// sorted key table: ordered record store with insert, remove, rank and indexed read
//
// one command per transfer on the slave stream: tuser carries the command,
// tdata the key, payload handle and index. one result per command leaves on
// the master stream: tuser carries the status, tdata rank, found key, found
// payload and the entry count after the command.
// the table lives in one ram of CAPACITY entries, kept in ascending key order,
// and a single key comparator walks it one entry per cycle. an insert walks
// down from the top moving entries up, a remove or position scans up from
// entry 0 and a remove then moves the tail down. a read at index fetches a
// single entry and a rejected command goes straight to its result. the result
// turns valid as the block turns ready again. s_axis_tready is high only while
// no command is in progress. results sit in an output register, so a new
// command is taken while a result waits; a command that finishes while the
// output register is still full holds until the receiver takes the older
// result.
// reset empties the table at once (the count clears, the ram is not swept).
module sorted_key_table_top
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // key, payload, index, zero pad
  input  logic [CMD_W-1:0]     s_axis_tuser,  // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // rank, found_key, found_payload,
                                              // entry_count, zero pad
  output logic [ST_W-1:0]      m_axis_tuser   // status
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = KEY_W + PAYLOAD_BITS;
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_TWO = CW'(2);
  localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);
  localparam logic [CW+4:0] RANK_ONE = (CW+5)'(1);

  state_e                  state_q, state_d;
  cmd_e                    cmd_q, cmd_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [CW-1:0]           ptr_q, ptr_d;
  logic [CW-1:0]           cnt_q, cnt_d;

  status_e                 res_status_q, res_status_d;
  logic [OUT_CNT_W-1:0]    res_rank_q, res_rank_d;
  logic [KEY_W-1:0]        res_key_q, res_key_d;
  logic [PAY_W-1:0]        res_pay_q, res_pay_d;

  logic                    m_valid_q, m_valid_d;
  status_e                 m_status_q, m_status_d;
  logic [OUT_CNT_W-1:0]    m_rank_q, m_rank_d;
  logic [KEY_W-1:0]        m_key_q, m_key_d;
  logic [PAY_W-1:0]        m_pay_q, m_pay_d;
  logic [OUT_CNT_W-1:0]    m_cnt_q, m_cnt_d;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [DW-1:0]           ram_wdata, ram_rdata;

  cmd_e                    in_cmd;
  logic [KEY_W-1:0]        in_key;
  logic [PAY_W-1:0]        in_pay;
  logic [IDX_W-1:0]        in_idx;
  logic [PAYLOAD_BITS+PAY_W-1:0] in_pay_x;
  logic [PAYLOAD_BITS+PAY_W-1:0] rd_pay_x;
  logic [CW+IDX_W-1:0]     idx_x, cnt_xi;
  logic [CW+4:0]           rank_x, cnt_x;
  logic [KEY_W-1:0]        rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    key_lt, key_eq;
  logic                    in_xfer, out_free;
  logic [CW-1:0]           ptr_p1, ptr_p2, ptr_m1, ptr_m2, cnt_m1;

  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_key   = s_axis_tdata[KEY_W-1:0];
  assign in_pay   = s_axis_tdata[KEY_W+PAY_W-1:KEY_W];
  assign in_idx   = s_axis_tdata[S_USED_W-1:KEY_W+PAY_W];
  assign in_pay_x = {{PAYLOAD_BITS{1'b0}}, in_pay};

  assign rd_key   = ram_rdata[DW-1:PAYLOAD_BITS];
  assign rd_pay   = ram_rdata[PAYLOAD_BITS-1:0];
  assign rd_pay_x = {{PAY_W{1'b0}}, rd_pay};
  assign key_lt   = rd_key < key_q;
  assign key_eq   = rd_key == key_q;

  assign idx_x    = {{CW{1'b0}}, in_idx};
  assign cnt_xi   = {{IDX_W{1'b0}}, cnt_q};
  assign rank_x   = {5'b0, ptr_q} + RANK_ONE;
  assign cnt_x    = {5'b0, cnt_d};

  assign ptr_p1   = ptr_q + CNT_ONE;
  assign ptr_p2   = ptr_q + CNT_TWO;
  assign ptr_m1   = ptr_q - CNT_ONE;
  assign ptr_m2   = ptr_q - CNT_TWO;
  assign cnt_m1   = cnt_q - CNT_ONE;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    pay_d        = pay_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_rank_d   = res_rank_q;
    res_key_d    = res_key_q;
    res_pay_d    = res_pay_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q[AW-1:0];
    ram_wdata    = {key_q, pay_q};
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d        = in_cmd;
          key_d        = in_key;
          pay_d        = in_pay_x[PAYLOAD_BITS-1:0];
          res_status_d = ST_OK;
          res_rank_d   = '0;
          res_key_d    = '0;
          res_pay_d    = '0;
          ptr_d        = '0;
          unique case (in_cmd)
            CMD_INSERT: begin
              if (cnt_q == CNT_CAP) begin
                res_status_d = ST_FULL;
                state_d      = S_DONE;
              end else if (cnt_q == '0) begin
                state_d = S_PLACE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[AW-1:0];
                ptr_d     = cnt_q;
                state_d   = S_SHIFT_UP;
              end
            end
            CMD_REMOVE, CMD_POSITION: begin
              if (cnt_q == '0) begin
                res_status_d = ST_NOT_FOUND;
                state_d      = S_DONE;
              end else begin
                ram_re  = 1'b1;
                state_d = S_SCAN;
              end
            end
            CMD_READ_AT: begin
              if (idx_x >= cnt_xi) begin
                res_status_d = ST_RANGE;
                state_d      = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = idx_x[AW-1:0];
                state_d   = S_FETCH;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (key_lt) begin
          if (ptr_p1 == cnt_q) begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_p1[AW-1:0];
            ptr_d     = ptr_p1;
          end
        end else if (!key_eq) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else if (cmd_q == CMD_POSITION) begin
          res_rank_d = rank_x[OUT_CNT_W-1:0];
          state_d    = S_DONE;
        end else if (ptr_p1 == cnt_q) begin
          cnt_d   = cnt_m1;
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_p1[AW-1:0];
          state_d   = S_SHIFT_DN;
        end
      end
      S_SHIFT_DN: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (ptr_p2 < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_p2[AW-1:0];
          ptr_d     = ptr_p1;
        end else begin
          cnt_d   = cnt_m1;
          state_d = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        ram_we = 1'b1;
        if (!key_lt) begin
          ram_wdata = ram_rdata;
          if (ptr_q == CNT_ONE) begin
            ptr_d   = '0;
            state_d = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_m2[AW-1:0];
            ptr_d     = ptr_m1;
          end
        end else begin
          cnt_d   = cnt_q + CNT_ONE;
          state_d = S_DONE;
        end
      end
      S_PLACE: begin
        ram_we  = 1'b1;
        cnt_d   = cnt_q + CNT_ONE;
        state_d = S_DONE;
      end
      S_FETCH: begin
        res_key_d = rd_key;
        res_pay_d = rd_pay_x[PAY_W-1:0];
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d  = m_valid_q;
    m_status_d = m_status_q;
    m_rank_d   = m_rank_q;
    m_key_d    = m_key_q;
    m_pay_d    = m_pay_q;
    m_cnt_d    = m_cnt_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      m_valid_d  = 1'b1;
      m_status_d = res_status_q;
      m_rank_d   = res_rank_q;
      m_key_d    = res_key_q;
      m_pay_d    = res_pay_q;
      m_cnt_d    = cnt_x[OUT_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_rank_q   <= res_rank_d;
    res_key_q    <= res_key_d;
    res_pay_q    <= res_pay_d;
    m_status_q   <= m_status_d;
    m_rank_q     <= m_rank_d;
    m_key_q      <= m_key_d;
    m_pay_q      <= m_pay_d;
    m_cnt_q      <= m_cnt_d;
  end

  skt_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, m_cnt_q, m_pay_q, m_key_q, m_rank_q};

endmodule
